// File: hw/rtl/rcpa_pkg.sv
// Package for the radio command decoder: level window constants, switch codes,
// mode and action codes, config register indexes and the gripper band function.
// No dependencies.
`timescale 1ns / 1ps

package rcpa_pkg;

  localparam int LEVEL_W  = 16;
  localparam int GAIN_W   = 7;
  localparam int CMD_W    = 8;
  localparam int ANGLE_W  = 9;
  localparam int ACTION_W = 2;
  localparam int GRIP_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [LEVEL_W-1:0] LVL_LOW   = 16'd87;
  localparam logic [LEVEL_W-1:0] LVL_MID   = 16'd118;
  localparam logic [LEVEL_W-1:0] LVL_HIGH  = 16'd179;
  localparam logic [LEVEL_W-1:0] BAND_HALF = 16'd5;

  localparam logic [LEVEL_W-1:0] CODE_IDLE  = 16'd118;
  localparam logic [LEVEL_W-1:0] CODE_ARM   = 16'd176;
  localparam logic [LEVEL_W-1:0] CODE_MOTOR = 16'd8571;

  // reciprocal multipliers: x/61 for x < 7748, x/31 for x < 3938, exact
  localparam int DIV61_K  = 8595;
  localparam int DIV61_SH = 19;
  localparam int DIV31_K  = 4229;
  localparam int DIV31_SH = 17;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_ARM   = 3'b010,
    MODE_MOTOR = 3'b100
  } mode_t;

  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ARM   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MOTOR = 2'd2;

  localparam logic [GRIP_W-1:0] GRIP_LOW  = 2'd0;
  localparam logic [GRIP_W-1:0] GRIP_MID  = 2'd1;
  localparam logic [GRIP_W-1:0] GRIP_HIGH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ARM_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_GAIN   = 2'd3;

  localparam logic [GAIN_W-1:0] RST_ARM_GAIN     = 7'd100;
  localparam logic [GAIN_W-1:0] RST_SERVO_GAIN   = 7'd90;
  localparam logic [GAIN_W-1:0] RST_SERVO_OFFSET = 7'd30;
  localparam logic [GAIN_W-1:0] RST_MOTOR_GAIN   = 7'd100;

  function automatic logic [GRIP_W-1:0] grip_band(input logic [LEVEL_W-1:0] v);
    logic [GRIP_W-1:0] b;
    b = GRIP_MID;
    if (v >= LVL_LOW && v <= LVL_LOW + BAND_HALF) begin
      b = GRIP_LOW;
    end else if (v >= LVL_MID && v <= LVL_MID + BAND_HALF) begin
      b = GRIP_MID;
    end else if (v >= LVL_HIGH - BAND_HALF && v <= LVL_HIGH + BAND_HALF) begin
      b = GRIP_HIGH;
    end
    return b;
  endfunction

endpackage

// File: hw/rtl/rcpa_if.sv
// Valid/ready channel interfaces for the receiver frame input and the command output.
// Depends on rcpa_pkg.
`timescale 1ns / 1ps

interface rcpa_in_if;
  import rcpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] switch_code;
  logic [LEVEL_W-1:0] travel_level;
  logic [LEVEL_W-1:0] yaw_level;
  logic [LEVEL_W-1:0] roll_level;
  logic [LEVEL_W-1:0] grip_level;

  modport source (output valid, switch_code, travel_level, yaw_level, roll_level,
                  grip_level, input ready);
  modport sink (input valid, switch_code, travel_level, yaw_level, roll_level,
                grip_level, output ready);
endinterface

interface rcpa_out_if;
  import rcpa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic signed [CMD_W-1:0]   arm_travel;
  logic signed [ANGLE_W-1:0] yaw_angle;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic [GRIP_W-1:0]         grip_state;
  logic signed [CMD_W-1:0]   left_drive;
  logic signed [CMD_W-1:0]   right_drive;

  modport source (output valid, action, arm_travel, yaw_angle, roll_angle, grip_state,
                  left_drive, right_drive, input ready);
  modport sink (input valid, action, arm_travel, yaw_angle, roll_angle, grip_state,
                left_drive, right_drive, output ready);
endinterface

// File: hw/rtl/rc_pulse_to_arm_command_unit.sv
// Top level of the radio command decoder: input register, mode register, decode, result register.
// Depends on rcpa_pkg, rcpa_if and rcpa_level_map.
//
// Usage:
//   in_ch carries one frame of receiver levels (switch, travel, yaw, roll, grip);
//   out_ch carries one command per frame: action code plus arm/servo values or
//   motor drives. Both channels transfer when valid and ready are high together.
//   cfg_we/cfg_idx/cfg_wdata write the four 7-bit gain/offset registers; write
//   only while no frame is in flight.
//   Path: a transferred frame waits in the input register, then one decode pass
//   moves it into the result register, which drives out_ch.
//   Throughput: one frame per cycle while out_ch is not held, set by the single
//   decode pass between the input register and the result register.
//   The mode register updates as a frame moves into the result register, so
//   frames are decoded strictly in order.
//   Reset: mode returns to idle, the gains take their reset values, both
//   pipeline stages empty.
//   Stall: while out_ch is held, the result holds, one more frame waits in the
//   input register, and in_ch.ready drops once that register is full.
`timescale 1ns / 1ps

module rc_pulse_to_arm_command_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  rcpa_in_if.sink                        in_ch,
  rcpa_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rcpa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rcpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rcpa_pkg::*;

  logic [GAIN_W-1:0] arm_gain_r, servo_gain_r, servo_offset_r, motor_gain_r;
  mode_t             mode_r, mode_nxt;

  logic               s1_valid_r;
  logic [LEVEL_W-1:0] s1_sw_r, s1_travel_r, s1_yaw_r, s1_roll_r, s1_grip_r;
  logic               advance;

  logic                      out_valid_r;
  logic [ACTION_W-1:0]       action_r, action_nxt;
  logic signed [CMD_W-1:0]   arm_travel_r, arm_travel_nxt;
  logic signed [ANGLE_W-1:0] yaw_angle_r, yaw_angle_nxt;
  logic signed [ANGLE_W-1:0] roll_angle_r, roll_angle_nxt;
  logic [GRIP_W-1:0]         grip_state_r, grip_state_nxt;
  logic signed [CMD_W-1:0]   left_drive_r, left_drive_nxt;
  logic signed [CMD_W-1:0]   right_drive_r, right_drive_nxt;

  logic [GAIN_W-1:0]       side_gain;
  logic signed [CMD_W-1:0] travel_cmd, yaw_cmd, roll_cmd;
  logic signed [ANGLE_W-1:0] offset_s;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_gain_r     <= RST_ARM_GAIN;
      servo_gain_r   <= RST_SERVO_GAIN;
      servo_offset_r <= RST_SERVO_OFFSET;
      motor_gain_r   <= RST_MOTOR_GAIN;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ARM_GAIN:     arm_gain_r     <= cfg_wdata;
        CFG_SERVO_GAIN:   servo_gain_r   <= cfg_wdata;
        CFG_SERVO_OFFSET: servo_offset_r <= cfg_wdata;
        CFG_MOTOR_GAIN:   motor_gain_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sw_r     <= in_ch.switch_code;
      s1_travel_r <= in_ch.travel_level;
      s1_yaw_r    <= in_ch.yaw_level;
      s1_roll_r   <= in_ch.roll_level;
      s1_grip_r   <= in_ch.grip_level;
    end
  end

  always_comb begin
    if (s1_sw_r == CODE_MOTOR) begin
      mode_nxt = MODE_MOTOR;
    end else if (s1_sw_r == CODE_IDLE) begin
      mode_nxt = MODE_IDLE;
    end else if (s1_sw_r == CODE_ARM) begin
      mode_nxt = MODE_ARM;
    end else begin
      mode_nxt = mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (advance) begin
      mode_r <= mode_nxt;
    end
  end

  // yaw and roll share one mapper each; gain follows the mode
  assign side_gain = (mode_nxt == MODE_MOTOR) ? motor_gain_r : servo_gain_r;
  assign offset_s  = $signed({2'b00, servo_offset_r});

  rcpa_level_map u_map_travel (.level(s1_travel_r), .gain(arm_gain_r), .cmd(travel_cmd));
  rcpa_level_map u_map_yaw    (.level(s1_yaw_r),    .gain(side_gain),  .cmd(yaw_cmd));
  rcpa_level_map u_map_roll   (.level(s1_roll_r),   .gain(side_gain),  .cmd(roll_cmd));

  always_comb begin
    action_nxt      = ACT_NONE;
    arm_travel_nxt  = '0;
    yaw_angle_nxt   = '0;
    roll_angle_nxt  = '0;
    grip_state_nxt  = GRIP_MID;
    left_drive_nxt  = '0;
    right_drive_nxt = '0;
    case (mode_nxt)
      MODE_ARM: begin
        action_nxt     = ACT_ARM;
        arm_travel_nxt = travel_cmd;
        yaw_angle_nxt  = ANGLE_W'(yaw_cmd) + offset_s;
        roll_angle_nxt = ANGLE_W'(roll_cmd) + offset_s;
        grip_state_nxt = grip_band(s1_grip_r);
      end
      MODE_MOTOR: begin
        action_nxt      = ACT_MOTOR;
        left_drive_nxt  = yaw_cmd;
        right_drive_nxt = roll_cmd;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action_r      <= action_nxt;
      arm_travel_r  <= arm_travel_nxt;
      yaw_angle_r   <= yaw_angle_nxt;
      roll_angle_r  <= roll_angle_nxt;
      grip_state_r  <= grip_state_nxt;
      left_drive_r  <= left_drive_nxt;
      right_drive_r <= right_drive_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.action      = action_r;
  assign out_ch.arm_travel  = arm_travel_r;
  assign out_ch.yaw_angle   = yaw_angle_r;
  assign out_ch.roll_angle  = roll_angle_r;
  assign out_ch.grip_state  = grip_state_r;
  assign out_ch.left_drive  = left_drive_r;
  assign out_ch.right_drive = right_drive_r;

  // checks
  a_motor_code_sets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_sw_r == CODE_MOTOR) |=> (mode_r == MODE_MOTOR && action_r == ACT_MOTOR))
    else $error("motor switch code did not select motor mode");

  a_arm_fields_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && action_r != ACT_ARM) |->
      (arm_travel_r == '0 && yaw_angle_r == '0 && roll_angle_r == '0 &&
       grip_state_r == GRIP_MID))
    else $error("arm fields driven outside arm action");

  a_drive_fields_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && action_r != ACT_MOTOR) |-> (left_drive_r == '0 && right_drive_r == '0))
    else $error("motor drives driven outside motor action");

  a_result_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(action_r) && $stable(mode_r)))
    else $error("result or mode changed while output stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input not ready with empty input register");

endmodule

// File: hw/rtl/rcpa_level_map.sv
// Maps one receiver level to a signed command scaled by a gain.
// Depends on rcpa_pkg.
`timescale 1ns / 1ps

module rcpa_level_map (
  input  logic [rcpa_pkg::LEVEL_W-1:0]      level,
  input  logic [rcpa_pkg::GAIN_W-1:0]       gain,
  output logic signed [rcpa_pkg::CMD_W-1:0] cmd
);
  import rcpa_pkg::*;

  logic        in_rng;
  logic        above;
  logic [5:0]  dp;
  logic [4:0]  dn;
  logic [5:0]  mag;
  logic [12:0] prod;
  logic [26:0] pprod;
  logic [24:0] nprod;
  logic [6:0]  q;

  assign in_rng = (level >= LVL_LOW) && (level <= LVL_HIGH);
  assign above  = (level >= LVL_MID);
  assign dp     = 6'(level[7:0] - LVL_MID[7:0]);
  assign dn     = 5'(LVL_MID[7:0] - level[7:0]);
  assign mag    = above ? dp : {1'b0, dn};
  assign prod   = 13'(mag) * 13'(gain);
  assign pprod  = 27'(prod) * 27'(DIV61_K);
  assign nprod  = 25'(prod[11:0]) * 25'(DIV31_K);
  assign q      = above ? 7'(pprod >> DIV61_SH) : 7'(nprod >> DIV31_SH);

  always_comb begin
    if (!in_rng) begin
      cmd = '0;
    end else if (above) begin
      cmd = $signed({1'b0, q});
    end else begin
      cmd = -$signed({1'b0, q});
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench for rc_pulse_to_arm_command_unit: directed frame table plus randomized
// frames under several gain settings, checked against an in-bench command decoder or the table's expected commands.
// Depends on rcpa_pkg, rcpa_if and the RTL of the unit.
`timescale 1ns / 1ps

module tb;
  import rcpa_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_FRAMES = 150;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [LEVEL_W-1:0] sw;
    logic [LEVEL_W-1:0] travel;
    logic [LEVEL_W-1:0] yaw;
    logic [LEVEL_W-1:0] roll;
    logic [LEVEL_W-1:0] grip;
  } frame_t;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [CMD_W-1:0]   travel;
    logic signed [ANGLE_W-1:0] yaw;
    logic signed [ANGLE_W-1:0] roll;
    logic [GRIP_W-1:0]         grip;
    logic signed [CMD_W-1:0]   left_drv;
    logic signed [CMD_W-1:0]   right_drv;
  } cmd_t;

  typedef struct packed {
    frame_t frame;
    bit     typed;
    cmd_t   want;
  } dir_row_t;

  localparam cmd_t NO_DRIVE = '{ACT_NONE, '0, '0, '0, GRIP_MID, '0, '0};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rcpa_in_if  in_ch();
  rcpa_out_if out_ch();

  rc_pulse_to_arm_command_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder state and register copy
  mode_t              cur_mode   = MODE_IDLE;
  logic [GAIN_W-1:0]  gain_arm   = RST_ARM_GAIN;
  logic [GAIN_W-1:0]  gain_servo = RST_SERVO_GAIN;
  logic [GAIN_W-1:0]  servo_ofs  = RST_SERVO_OFFSET;
  logic [GAIN_W-1:0]  gain_motor = RST_MOTOR_GAIN;

  cmd_t     cmd_q[$];
  dir_row_t dir_rows[$];
  int       errors  = 0;
  int       results = 0;
  int       cycles  = 0;
  bit       tx_idle = 1'b1;
  bit       rx_idle = 1'b1;
  int       hold_len = 0;
  bit       cur_typed = 1'b0;
  cmd_t     cur_want;

  function automatic int map_level(input logic [LEVEL_W-1:0] lvl, input logic [GAIN_W-1:0] g);
    int d;
    if (lvl < LVL_LOW || lvl > LVL_HIGH) return 0;
    d = int'(lvl) - int'(LVL_MID);
    if (d >= 0) return (d * int'(g)) / int'(LVL_HIGH - LVL_MID);
    return -(((-d) * int'(g)) / int'(LVL_MID - LVL_LOW));
  endfunction

  function automatic logic [GRIP_W-1:0] grip_of(input logic [LEVEL_W-1:0] v);
    if (v inside {[LVL_LOW : LVL_LOW + BAND_HALF]}) return GRIP_LOW;
    if (v inside {[LVL_HIGH - BAND_HALF : LVL_HIGH + BAND_HALF]}) return GRIP_HIGH;
    return GRIP_MID;
  endfunction

  function automatic cmd_t decode_frame(input frame_t f);
    cmd_t c;
    case (f.sw)
      CODE_MOTOR: cur_mode = MODE_MOTOR;
      CODE_IDLE:  cur_mode = MODE_IDLE;
      CODE_ARM:   cur_mode = MODE_ARM;
      default: ;
    endcase
    c = NO_DRIVE;
    if (cur_mode == MODE_ARM) begin
      c.action = ACT_ARM;
      c.travel = CMD_W'(map_level(f.travel, gain_arm));
      c.yaw    = ANGLE_W'(map_level(f.yaw, gain_servo) + int'(servo_ofs));
      c.roll   = ANGLE_W'(map_level(f.roll, gain_servo) + int'(servo_ofs));
      c.grip   = grip_of(f.grip);
    end else if (cur_mode == MODE_MOTOR) begin
      c.action    = ACT_MOTOR;
      c.left_drv  = CMD_W'(map_level(f.yaw, gain_motor));
      c.right_drv = CMD_W'(map_level(f.roll, gain_motor));
    end
    return c;
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    int r;
    logic [LEVEL_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      v = LEVEL_W'($urandom_range(80, 190));
    end else if (r < 85) begin
      case ($urandom_range(0, 10))
        0: v = LVL_LOW - 1;
        1: v = LVL_LOW;
        2: v = LVL_LOW + BAND_HALF + 1;
        3: v = LVL_MID - 1;
        4: v = LVL_MID;
        5: v = LVL_MID + BAND_HALF + 1;
        6: v = LVL_HIGH - BAND_HALF - 1;
        7: v = LVL_HIGH;
        8: v = LVL_HIGH + 1;
        9: v = LVL_HIGH + BAND_HALF;
        default: v = LVL_HIGH + BAND_HALF + 1;
      endcase
    end else begin
      v = LEVEL_W'($urandom());
    end
    return v;
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_switch();
    int r;
    logic [LEVEL_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 12) v = CODE_IDLE;
    else if (r < 24) v = CODE_ARM;
    else if (r < 36) v = CODE_MOTOR;
    else if (r < 46) begin
      case ($urandom_range(0, 5))
        0: v = CODE_IDLE - 1;
        1: v = CODE_IDLE + 1;
        2: v = CODE_ARM - 1;
        3: v = CODE_ARM + 1;
        4: v = CODE_MOTOR - 1;
        default: v = CODE_MOTOR + 1;
      endcase
    end else begin
      v = LEVEL_W'($urandom());
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("[%0t] result %0d: %s got %0d expected %0d", $time, results, what, got, want);
  endtask

  task automatic add_row(input frame_t f, input bit typed, input cmd_t want);
    dir_rows.push_back('{f, typed, want});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ARM_GAIN:     gain_arm   = val;
      CFG_SERVO_GAIN:   gain_servo = val;
      CFG_SERVO_OFFSET: servo_ofs  = val;
      CFG_MOTOR_GAIN:   gain_motor = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_t f, input bit typed, input cmd_t want);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.switch_code  <= f.sw;
    in_ch.travel_level <= f.travel;
    in_ch.yaw_level    <= f.yaw;
    in_ch.roll_level   <= f.roll;
    in_ch.grip_level   <= f.grip;
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (cmd_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // input side monitor: every transfer feeds the decoder
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin : accept
      cmd_t p;
      p = decode_frame('{in_ch.switch_code, in_ch.travel_level, in_ch.yaw_level,
                         in_ch.roll_level, in_ch.grip_level});
      cmd_q.push_back(cur_typed ? cur_want : p);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin : check
      cmd_t e;
      if (cmd_q.size() == 0) begin
        report_mismatch("unexpected result, action", out_ch.action, -1);
      end else begin
        e = cmd_q.pop_front();
        if (out_ch.action !== e.action)
          report_mismatch("action", out_ch.action, e.action);
        if (out_ch.arm_travel !== e.travel)
          report_mismatch("arm_travel", out_ch.arm_travel, e.travel);
        if (out_ch.yaw_angle !== e.yaw)
          report_mismatch("yaw_angle", out_ch.yaw_angle, e.yaw);
        if (out_ch.roll_angle !== e.roll)
          report_mismatch("roll_angle", out_ch.roll_angle, e.roll);
        if (out_ch.grip_state !== e.grip)
          report_mismatch("grip_state", out_ch.grip_state, e.grip);
        if (out_ch.left_drive !== e.left_drv)
          report_mismatch("left_drive", out_ch.left_drive, e.left_drv);
        if (out_ch.right_drive !== e.right_drv)
          report_mismatch("right_drive", out_ch.right_drive, e.right_drv);
      end
      results++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("** rc_pulse_to_arm_command_unit: FAILED **");
      $finish;
    end
  end

  // result receiver; a pending hold_len stalls it by holding out_ch.ready low
  initial begin : receiver
    int stall;
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      stall = rx_idle ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    frame_t f;
    logic [GAIN_W-1:0] g [4];
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.switch_code  = '0;
    in_ch.travel_level = '0;
    in_ch.yaw_level    = '0;
    in_ch.roll_level   = '0;
    in_ch.grip_level   = '0;
    cur_want           = NO_DRIVE;

    // directed frames under reset gains
    add_row('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, NO_DRIVE);
    add_row('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, NO_DRIVE);
    add_row('{CODE_ARM, 16'd179, 16'd179, 16'd87, 16'd87}, 1'b1,
            '{ACT_ARM, 8'sd100, 9'sd120, -9'sd60, GRIP_LOW, 8'sd0, 8'sd0});
    add_row('{16'h1234, 16'd87, 16'd118, 16'd118, 16'd179}, 1'b1,
            '{ACT_ARM, -8'sd100, 9'sd30, 9'sd30, GRIP_HIGH, 8'sd0, 8'sd0});
    add_row('{CODE_ARM, 16'd86, 16'd180, 16'hFFFF, 16'd92}, 1'b1,
            '{ACT_ARM, 8'sd0, 9'sd30, 9'sd30, GRIP_LOW, 8'sd0, 8'sd0});
    add_row('{16'hFFFF, 16'd119, 16'd117, 16'd150, 16'd93}, 1'b0, NO_DRIVE);
    add_row('{CODE_IDLE + 16'd1, 16'd120, 16'd100, 16'd160, 16'd174}, 1'b0, NO_DRIVE);
    add_row('{16'd0, 16'd140, 16'd88, 16'd178, 16'd184}, 1'b0, NO_DRIVE);
    add_row('{16'd0, 16'd95, 16'd130, 16'd110, 16'd185}, 1'b0, NO_DRIVE);
    add_row('{16'd0, 16'd118, 16'd118, 16'd118, 16'd173}, 1'b0, NO_DRIVE);
    add_row('{16'd0, 16'd100, 16'd100, 16'd100, 16'd123}, 1'b0, NO_DRIVE);
    add_row('{16'd0, 16'd100, 16'd100, 16'd100, 16'd86}, 1'b0, NO_DRIVE);
    add_row('{16'd0, 16'd100, 16'd100, 16'd100, 16'd124}, 1'b0, NO_DRIVE);
    add_row('{CODE_MOTOR, 16'd0, 16'd179, 16'd87, 16'd92}, 1'b1,
            '{ACT_MOTOR, 8'sd0, 9'sd0, 9'sd0, GRIP_MID, 8'sd100, -8'sd100});
    add_row('{CODE_ARM - 16'd1, 16'd50, 16'd0, 16'hFFFF, 16'd87}, 1'b1,
            '{ACT_MOTOR, 8'sd0, 9'sd0, 9'sd0, GRIP_MID, 8'sd0, 8'sd0});
    add_row('{CODE_MOTOR, 16'd0, 16'd150, 16'd100, 16'd0}, 1'b0, NO_DRIVE);
    add_row('{16'h5555, 16'hAAAA, 16'd120, 16'd90, 16'd180}, 1'b0, NO_DRIVE);
    add_row('{CODE_IDLE, 16'd179, 16'd179, 16'd179, 16'd179}, 1'b1, NO_DRIVE);
    add_row('{CODE_MOTOR + 16'd1, 16'd179, 16'd179, 16'd179, 16'd179}, 1'b1, NO_DRIVE);
    add_row('{CODE_ARM + 16'd1, 16'd87, 16'd87, 16'd87, 16'd87}, 1'b1, NO_DRIVE);
    add_row('{CODE_MOTOR - 16'd1, 16'd87, 16'd87, 16'd87, 16'd87}, 1'b1, NO_DRIVE);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_frame(dir_rows[i].frame, dir_rows[i].typed, dir_rows[i].want);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: g = '{7'd127, 7'd127, 7'd127, 7'd127};
        1: g = '{7'd0, 7'd0, 7'd0, 7'd0};
        2: g = '{7'd127, 7'd127, 7'd0, 7'd127};
        3: g = '{7'd1, 7'd1, 7'd1, 7'd1};
        4: g = '{RST_ARM_GAIN, RST_SERVO_GAIN, RST_SERVO_OFFSET, RST_MOTOR_GAIN};
        default: begin
          foreach (g[k]) g[k] = GAIN_W'($urandom_range(0, 127));
        end
      endcase
      write_reg(CFG_ARM_GAIN, g[0]);
      write_reg(CFG_SERVO_GAIN, g[1]);
      write_reg(CFG_SERVO_OFFSET, g[2]);
      write_reg(CFG_MOTOR_GAIN, g[3]);
      cfg_we <= 1'b0;
      tx_idle = (ph % 4 != 1) && (ph != 2);
      rx_idle = (ph % 3 != 2);
      // long output stall while frames keep coming back to back
      if (ph == 2) hold_len = HOLD_CYCLES;
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        f = '{rand_switch(), rand_level(), rand_level(), rand_level(), rand_level()};
        send_frame(f, 1'b0, NO_DRIVE);
      end
      drain();
    end

    if (errors == 0) begin
      $display("** rc_pulse_to_arm_command_unit: PASSED **");
    end else begin
      $display("** rc_pulse_to_arm_command_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: rc_pulse_to_arm_command_unit.f
hw/rtl/rcpa_pkg.sv
hw/rtl/rcpa_if.sv
hw/rtl/rcpa_level_map.sv
hw/rtl/rc_pulse_to_arm_command_unit.sv
tb/sv/tb.sv
